// ===== design/mpsm_pkg.sv =====
// Shared types, needle tables and sizing constants of the substring matcher.
package mpsm_pkg;

	localparam int MAX_TEXT_BYTES_DEF = 840;
	localparam int WINDOW_BYTES_DEF   = 13;

	localparam int CNT_W          = 10;
	localparam int NEEDLE_COUNT   = 26;
	localparam int CHEAT_COUNT    = 17;
	localparam int MAX_NEEDLE_LEN = 13;
	localparam int IDX_W          = 5;
	localparam int SIG_W          = 5;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_Z    = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;
	localparam logic [7:0] NUL_BYTE   = 8'h00;

	localparam logic CAT_CHEAT = 1'b0;
	localparam logic CAT_DEBUG = 1'b1;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_item_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] needle_index;
		logic [SIG_W-1:0] signature_id;
		logic             category;
	} result_t;

	// One classified byte on its way from the front to the back.
	typedef struct packed {
		logic [7:0] folded;
		logic       use_byte;
		logic       last;
	} queue_entry_t;

	// Needle bytes in text order, zero padded to the longest needle.
	localparam logic [7:0] NEEDLE_TXT [0:NEEDLE_COUNT-1][0:MAX_NEEDLE_LEN-1] = '{
		'{8'h78,8'h72,8'h61,8'h79,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h77,8'h75,8'h72,8'h73,8'h74,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h6d,8'h65,8'h74,8'h65,8'h6f,8'h72,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h69,8'h6d,8'h70,8'h61,8'h63,8'h74,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h61,8'h72,8'h69,8'h73,8'h74,8'h6f,8'h69,8'h73,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h62,8'h61,8'h72,8'h69,8'h74,8'h6f,8'h6e,8'h65,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h6b,8'h69,8'h6c,8'h6c,8'h61,8'h75,8'h72,8'h61,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h61,8'h69,8'h6d,8'h62,8'h6f,8'h74,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h61,8'h75,8'h74,8'h6f,8'h63,8'h6c,8'h69,8'h63,8'h6b,8'h65,8'h72,8'h00,8'h00},
		'{8'h63,8'h68,8'h65,8'h61,8'h74,8'h65,8'h6e,8'h67,8'h69,8'h6e,8'h65,8'h00,8'h00},
		'{8'h73,8'h63,8'h61,8'h6e,8'h6d,8'h65,8'h6d,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h67,8'h61,8'h6d,8'h65,8'h63,8'h6f,8'h6e,8'h71,8'h75,8'h65,8'h72,8'h6f,8'h72},
		'{8'h66,8'h72,8'h69,8'h64,8'h61,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h64,8'h6f,8'h62,8'h62,8'h79,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h73,8'h75,8'h62,8'h73,8'h74,8'h72,8'h61,8'h74,8'h65,8'h00,8'h00,8'h00,8'h00},
		'{8'h78,8'h70,8'h6f,8'h73,8'h65,8'h64,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h6c,8'h69,8'h6e,8'h75,8'h78,8'h2d,8'h69,8'h6e,8'h6a,8'h65,8'h63,8'h74,8'h00},
		'{8'h67,8'h64,8'h62,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h6c,8'h6c,8'h64,8'h62,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h70,8'h74,8'h72,8'h61,8'h63,8'h65,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h73,8'h74,8'h72,8'h61,8'h63,8'h65,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h6c,8'h74,8'h72,8'h61,8'h63,8'h65,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h72,8'h61,8'h64,8'h61,8'h72,8'h65,8'h32,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h67,8'h68,8'h69,8'h64,8'h72,8'h61,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h69,8'h64,8'h61,8'h36,8'h34,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
		'{8'h69,8'h64,8'h61,8'h33,8'h32,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
	};

	localparam int NEEDLE_LEN [0:NEEDLE_COUNT-1] = '{
		4, 5, 6, 6, 8, 8, 8, 6, 11, 11, 7, 13, 5, 5, 9, 6, 12,
		3, 4, 6, 6, 6, 7, 6, 5, 5
	};

	localparam logic [SIG_W-1:0] NEEDLE_SIG [0:NEEDLE_COUNT-1] = '{
		5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd9, 5'd9,
		5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
		5'd20, 5'd21, 5'd22, 5'd22
	};

endpackage

// ===== design/priority_multi_pattern_substring_matcher.sv =====
// A text's last byte passes through the queue and then the result register before its result appears.
// Throughput: one byte per cycle while the queue is not full; the needle compares all run in parallel in the back end.
// The two-entry queue lets the input keep transferring while a result waits on stall.
// Reset: arst_n clears counters, stop flag, history window, seen mask and queue at once;
// the block can take a byte in the first cycle after reset is released.
module priority_multi_pattern_substring_matcher import mpsm_pkg::*; #(
	parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF,
	parameter int WINDOW_BYTES   = WINDOW_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  text_item_t text_item,
	output logic       res_valid,
	input  logic       res_stall,
	output result_t    res_item
);

	// Handshake and payload between the three parts.
	logic         push;
	queue_entry_t push_entry;
	logic         q_full;
	logic         head_valid;
	queue_entry_t head;
	logic         pop;

	// Hold the input off only when the queue has no room; this is registered state,
	// so the stall never depends on the incoming valid.
	assign text_stall = q_full;

	// Fold case and decide per byte whether it takes part in matching; a zero byte and the
	// bytes after it, or bytes past the length limit, are excluded until the text ends.
	mpsm_front #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_item (text_item),
		.full      (q_full),
		.push      (push),
		.entry     (push_entry)
	);

	// Decouple the two ends so a stalled result does not block the input at once.
	mpsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.full      (q_full)
	);

	// Advance the window, compare all needles in parallel, and on the last byte
	// register the highest-priority hit and clear the window and mask.
	mpsm_back #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

// ===== design/mpsm_front.sv =====
// Front end: case folding, zero-byte and length stop, byte counting.
module mpsm_front import mpsm_pkg::*; #(
	parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         text_valid,
	input  text_item_t   text_item,
	input  logic         full,
	output logic         push,
	output queue_entry_t entry
);

	localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_TEXT_BYTES - 1);

	logic [CNT_W-1:0] count_q;
	logic             stopped_q;
	logic             use_byte;

	assign push     = text_valid && !full;
	assign use_byte = !stopped_q && (text_item.text_byte != NUL_BYTE)
		&& (count_q < COUNT_LIMIT);

	always_comb begin
		entry.folded   = text_item.text_byte;
		entry.use_byte = use_byte;
		entry.last     = text_item.last_byte;
		if (text_item.text_byte inside {[UPPER_A:UPPER_Z]}) begin
			entry.folded = text_item.text_byte + CASE_DELTA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else if (push) begin
			if (text_item.last_byte) begin
				count_q   <= '0;
				stopped_q <= 1'b0;
			end else if (use_byte) begin
				count_q <= count_q + 1'b1;
			end else begin
				stopped_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/mpsm_queue.sv =====
// Two-entry queue between the front and back ends.
module mpsm_queue import mpsm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_entry,
	input  logic         pop,
	output logic         head_valid,
	output queue_entry_t head,
	output logic         full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	queue_entry_t      slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] fill_q;
	logic              do_pop;

	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign full       = (fill_q == CNT_QW'(QUEUE_DEPTH));
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mpsm_back.sv =====
// Back end: history window, parallel needle compare, seen mask and result register.
module mpsm_back import mpsm_pkg::*; #(
	parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  queue_entry_t head,
	output logic         pop,
	output logic         res_valid,
	input  logic         res_stall,
	output result_t      res_item
);

	localparam int HIST_LEN = WINDOW_BYTES - 1;

	logic [7:0]              window_q [HIST_LEN];
	logic [NEEDLE_COUNT-1:0] seen_q;
	logic [NEEDLE_COUNT-1:0] match_vec;
	logic [NEEDLE_COUNT-1:0] mask_next;
	logic                    out_free;
	result_t                 result_next;
	logic                    res_valid_q;
	result_t                 res_item_q;

	for (genvar n = 0; n < NEEDLE_COUNT; n++) begin : g_cmp
		localparam int LEN = NEEDLE_LEN[n];
		always_comb begin
			logic m;
			m = (NEEDLE_TXT[n][LEN-1] == head.folded);
			for (int k = 1; k < LEN; k++) begin
				m = m && (NEEDLE_TXT[n][LEN-1-k] == window_q[k-1]);
			end
			match_vec[n] = m;
		end
	end

	assign mask_next = seen_q | (head.use_byte ? match_vec : '0);
	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = head_valid && (!head.last || out_free);

	// Lowest set bit wins: scan from the top so the last write is the lowest.
	always_comb begin
		result_next = '0;
		for (int i = NEEDLE_COUNT - 1; i >= 0; i--) begin
			if (mask_next[i]) begin
				result_next.hit          = 1'b1;
				result_next.needle_index = IDX_W'(i);
				result_next.signature_id = NEEDLE_SIG[i];
				result_next.category     = (i >= CHEAT_COUNT) ? CAT_DEBUG : CAT_CHEAT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int j = 0; j < HIST_LEN; j++) begin
				window_q[j] <= '0;
			end
		end else if (pop) begin
			if (head.last) begin
				seen_q <= '0;
				for (int j = 0; j < HIST_LEN; j++) begin
					window_q[j] <= '0;
				end
			end else begin
				seen_q <= mask_next;
				if (head.use_byte) begin
					window_q[0] <= head.folded;
					for (int j = 1; j < HIST_LEN; j++) begin
						window_q[j] <= window_q[j-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= pop && head.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pop && head.last) begin
			res_item_q <= result_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule
